### design/sts_pkg.sv
`timescale 1ns / 1ps

package sts_pkg;

   // lamps driven per side; the ports always show four
   localparam int LampsPerSide = 4;
   localparam int OutLamps     = 4;
   localparam int LampIdxW     = (LampsPerSide > 1) ? $clog2(LampsPerSide) : 1;

   localparam int LevelW = 7;
   localparam int HoldW  = 8;
   localparam int SweepW = 4;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 8;

   localparam logic [LevelW-1:0] FullLevel = LevelW'(100);

   typedef logic [LevelW-1:0] level_type;
   typedef logic [LampsPerSide-1:0][LevelW-1:0] lamps_type;

   // tick kinds
   typedef enum logic {
      OP_BLINK  = 1'b0,
      OP_LIGHTS = 1'b1
   } op_type;

   // register indexes of the configuration port
   typedef enum logic [CsrIdxW-1:0] {
      CSR_RAMP_STEP    = 3'd0,
      CSR_HOLD_STEPS   = 3'd1,
      CSR_REPEAT_COUNT = 3'd2,
      CSR_EDGE_LEVEL   = 3'd3,
      CSR_TAIL_LEVEL   = 3'd4
   } csr_index_type;

   localparam logic [LevelW-1:0] RampStepReset    = LevelW'(5);
   localparam logic [HoldW-1:0]  HoldStepsReset   = HoldW'(6);
   localparam logic [SweepW-1:0] RepeatCountReset = SweepW'(3);
   localparam logic [LevelW-1:0] EdgeLevelReset   = LevelW'(20);
   localparam logic [LevelW-1:0] TailLevelReset   = LevelW'(5);

   typedef struct packed {
      logic [LevelW-1:0] ramp_step;
      logic [HoldW-1:0]  hold_steps;
      logic [SweepW-1:0] repeat_count;
      logic [LevelW-1:0] edge_level;
      logic [LevelW-1:0] tail_level;
   } cfg_type;

   // per-side command for one transaction
   typedef struct packed {
      logic step;        // a transaction is being committed
      logic blink;       // it is a blink step
      logic request;     // side button pressed
      logic lights_off;  // lights step switching the lights off
   } side_cmd_type;

   // clamp a level register to full brightness
   function automatic level_type sat_level(input level_type v);
      sat_level = (v > FullLevel) ? FullLevel : v;
   endfunction

endpackage

### design/sts_csr.sv
`timescale 1ns / 1ps

module sts_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [sts_pkg::CsrIdxW-1:0]          csr_index,
   input  logic [sts_pkg::CsrDataW-1:0]         csr_wdata,
   output sts_pkg::cfg_type                     cfg
);

   sts_pkg::cfg_type cfg_ff;
   sts_pkg::cfg_type cfg_in;

   // register decode, each write masked to its width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (sts_pkg::csr_index_type'(csr_index))
            sts_pkg::CSR_RAMP_STEP:
               cfg_in.ramp_step = csr_wdata[sts_pkg::LevelW-1:0];
            sts_pkg::CSR_HOLD_STEPS:
               cfg_in.hold_steps = csr_wdata[sts_pkg::HoldW-1:0];
            sts_pkg::CSR_REPEAT_COUNT:
               cfg_in.repeat_count = csr_wdata[sts_pkg::SweepW-1:0];
            sts_pkg::CSR_EDGE_LEVEL:
               cfg_in.edge_level = csr_wdata[sts_pkg::LevelW-1:0];
            sts_pkg::CSR_TAIL_LEVEL:
               cfg_in.tail_level = csr_wdata[sts_pkg::LevelW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_step    <= sts_pkg::RampStepReset;
         cfg_ff.hold_steps   <= sts_pkg::HoldStepsReset;
         cfg_ff.repeat_count <= sts_pkg::RepeatCountReset;
         cfg_ff.edge_level   <= sts_pkg::EdgeLevelReset;
         cfg_ff.tail_level   <= sts_pkg::TailLevelReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/sts_side.sv
`timescale 1ns / 1ps

// one blinker side; lamps are held in ramp order, index 0 ramps first
module sts_side (
   input  logic                 clock,
   input  logic                 reset,
   input  sts_pkg::side_cmd_type cmd,
   input  sts_pkg::cfg_type     cfg,
   output sts_pkg::lamps_type   levels
);

   sts_pkg::lamps_type              levels_ff, levels_in;
   logic                            active_ff, active_in;
   logic [sts_pkg::HoldW-1:0]       hold_ff, hold_in;
   logic [sts_pkg::SweepW-1:0]      sweeps_ff, sweeps_in;

   logic                            found;
   logic [sts_pkg::LampIdxW-1:0]    sel;
   logic [sts_pkg::LevelW:0]        sum;
   logic                            act;

   // first lamp below full, in ramp order
   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int k = sts_pkg::LampsPerSide - 1; k >= 0; k--) begin
         if (levels_ff[k] < sts_pkg::FullLevel) begin
            found = 1'b1;
            sel   = sts_pkg::LampIdxW'(k);
         end
      end
   end

   assign sum = {1'b0, levels_ff[sel]} + {1'b0, cfg.ramp_step};
   assign act = active_ff | cmd.request;

   // ramp, hold, clear and sweep count
   always_comb begin
      levels_in = levels_ff;
      active_in = active_ff;
      hold_in   = hold_ff;
      sweeps_in = sweeps_ff;
      if (cmd.step && cmd.blink) begin
         active_in = act;
         if (act && (sweeps_ff < cfg.repeat_count)) begin
            if (found) begin
               levels_in[sel] = (sum > {1'b0, sts_pkg::FullLevel}) ?
                                sts_pkg::FullLevel : sum[sts_pkg::LevelW-1:0];
            end else if (hold_ff < cfg.hold_steps) begin
               hold_in = hold_ff + 1'b1;
            end else begin
               sweeps_in = sweeps_ff + 1'b1;
               hold_in   = '0;
               levels_in = '0;
            end
         end else begin
            sweeps_in = '0;
            active_in = 1'b0;
         end
      end else if (cmd.step && cmd.lights_off) begin
         levels_in = '0;
         active_in = 1'b0;
         hold_in   = '0;
         sweeps_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= '0;
         active_ff <= 1'b0;
         hold_ff   <= '0;
         sweeps_ff <= '0;
      end else begin
         levels_ff <= levels_in;
         active_ff <= active_in;
         hold_ff   <= hold_in;
         sweeps_ff <= sweeps_in;
      end
   end

   assign levels = levels_ff;

   // lights off leaves the side idle and dark
   a_lights_off_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.step && !cmd.blink && cmd.lights_off |=>
         !active_ff && hold_ff == '0 && sweeps_ff == '0 && levels_ff == '0)
      else $error("side not cleared by lights off");

   // state only moves when a transaction is committed
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !cmd.step |=> $stable(levels_ff) && $stable(hold_ff) && $stable(sweeps_ff))
      else $error("side state changed without a transaction");

   // an idle side never advances its sweep count
   a_idle_no_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.step && cmd.blink && !act |=> sweeps_ff == '0 && !active_ff)
      else $error("idle side did not settle");

endmodule

### design/sequential_turn_signal_sequencer.sv
`timescale 1ns / 1ps

// Sequential turn-signal and rear-light sequencer. Each req_ transaction is one
// tick: a blink step (op 0) ramps the active blinker lamps inner to outer by
// ramp_step, holds them full for hold_steps ticks and repeats for repeat_count
// sweeps; a lights step (op 1) sets the brake lamp and switches edge and tail
// lights on or off, and switching off also clears both blinkers. Every tick
// yields exactly one rsp_ transaction carrying all lamp levels in percent.
// A tick passes through an input register and is committed to the lamp state
// once the result slot is free; one tick is taken every cycle, and as the
// lamp state registers form the result register, throughput drops only
// while rsp_stall holds a result. The user writes configuration through csr_
// only while no transaction is in flight; the block does not enforce this.
module sequential_turn_signal_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_write,
   input  logic [sts_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [sts_pkg::CsrDataW-1:0]  csr_wdata,
   // ticks
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic                          req_left_request,
   input  logic                          req_right_request,
   input  logic                          req_brake_pressed,
   input  logic                          req_lights_pressed,
   // lamp levels
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sts_pkg::LevelW-1:0]    rsp_left_lamp0,
   output logic [sts_pkg::LevelW-1:0]    rsp_left_lamp1,
   output logic [sts_pkg::LevelW-1:0]    rsp_left_lamp2,
   output logic [sts_pkg::LevelW-1:0]    rsp_left_lamp3,
   output logic [sts_pkg::LevelW-1:0]    rsp_right_lamp0,
   output logic [sts_pkg::LevelW-1:0]    rsp_right_lamp1,
   output logic [sts_pkg::LevelW-1:0]    rsp_right_lamp2,
   output logic [sts_pkg::LevelW-1:0]    rsp_right_lamp3,
   output logic [sts_pkg::LevelW-1:0]    rsp_edge_lamps,
   output logic [sts_pkg::LevelW-1:0]    rsp_brake_lamp
);

   sts_pkg::cfg_type cfg;

   // input register
   logic in_valid_ff, in_valid_in;
   logic in_op_ff, in_left_ff, in_right_ff, in_brake_ff, in_lights_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_take, advance;

   // rear light state
   logic                        lights_on_ff, lights_on_in;
   logic [sts_pkg::LevelW-1:0]  edge_now_ff, edge_now_in;
   logic [sts_pkg::LevelW-1:0]  brake_now_ff, brake_now_in;

   sts_pkg::side_cmd_type left_cmd, right_cmd;
   sts_pkg::lamps_type    left_levels, right_levels;
   logic                  is_lights, lights_off;

   logic [sts_pkg::OutLamps-1:0][sts_pkg::LevelW-1:0] left_out, right_out;

   sts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // handshake: a tick commits when the result slot is free or being taken
   assign advance     = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // transaction payload register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff     <= req_op;
         in_left_ff   <= req_left_request;
         in_right_ff  <= req_right_request;
         in_brake_ff  <= req_brake_pressed;
         in_lights_ff <= req_lights_pressed;
      end
   end

   assign is_lights  = (sts_pkg::op_type'(in_op_ff) == sts_pkg::OP_LIGHTS);
   assign lights_off = is_lights && in_lights_ff && !in_brake_ff;

   // blinker sides
   always_comb begin
      left_cmd.step        = advance;
      left_cmd.blink       = !is_lights;
      left_cmd.request     = in_left_ff;
      left_cmd.lights_off  = lights_off;
      right_cmd.step       = advance;
      right_cmd.blink      = !is_lights;
      right_cmd.request    = in_right_ff;
      right_cmd.lights_off = lights_off;
   end

   sts_side u_left (
      .clock  (clock),
      .reset  (reset),
      .cmd    (left_cmd),
      .cfg    (cfg),
      .levels (left_levels)
   );

   sts_side u_right (
      .clock  (clock),
      .reset  (reset),
      .cmd    (right_cmd),
      .cfg    (cfg),
      .levels (right_levels)
   );

   // brake, tail and edge lights
   always_comb begin
      lights_on_in = lights_on_ff;
      edge_now_in  = edge_now_ff;
      brake_now_in = brake_now_ff;
      if (advance && is_lights) begin
         if (in_brake_ff) begin
            brake_now_in = sts_pkg::FullLevel;
         end else if (lights_on_ff) begin
            brake_now_in = sts_pkg::sat_level(cfg.tail_level);
         end else begin
            brake_now_in = '0;
         end
         if (in_lights_ff && in_brake_ff) begin
            edge_now_in  = sts_pkg::sat_level(cfg.edge_level);
            brake_now_in = sts_pkg::sat_level(cfg.tail_level);
            lights_on_in = 1'b1;
         end
         if (lights_off) begin
            edge_now_in  = '0;
            brake_now_in = '0;
            lights_on_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lights_on_ff <= 1'b0;
         edge_now_ff  <= '0;
         brake_now_ff <= '0;
      end else begin
         lights_on_ff <= lights_on_in;
         edge_now_ff  <= edge_now_in;
         brake_now_ff <= brake_now_in;
      end
   end

   // map lamps onto the fixed output ports; right side is stored inner first
   for (genvar j = 0; j < sts_pkg::OutLamps; j++) begin : g_out
      if (j < sts_pkg::LampsPerSide) begin : g_used
         assign left_out[j]  = left_levels[j];
         assign right_out[j] = right_levels[sts_pkg::LampsPerSide - 1 - j];
      end else begin : g_unused
         assign left_out[j]  = '0;
         assign right_out[j] = '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_lamp0  = left_out[0];
   assign rsp_left_lamp1  = left_out[1];
   assign rsp_left_lamp2  = left_out[2];
   assign rsp_left_lamp3  = left_out[3];
   assign rsp_right_lamp0 = right_out[0];
   assign rsp_right_lamp1 = right_out[1];
   assign rsp_right_lamp2 = right_out[2];
   assign rsp_right_lamp3 = right_out[3];
   assign rsp_edge_lamps  = edge_now_ff;
   assign rsp_brake_lamp  = brake_now_ff;

   // a committed tick always shows up as a result next cycle
   a_commit_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("committed transaction produced no result");

   // a held tick stays in the input register
   a_held_tick_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_op_ff))
      else $error("held transaction lost");

   // rear lights only move on a committed lights step
   a_rear_stable: assert property (@(posedge clock) disable iff (reset)
      !(advance && is_lights) |=> $stable(edge_now_ff) && $stable(lights_on_ff))
      else $error("rear lights changed without a lights step");

endmodule
